>>> sv/rmsd_pkg.sv
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared widths, reset values, register codes and types of the RMS current
// on/off detector.
// ----------------------------------------------------------------------------
package rmsd_pkg;

  localparam int SMP_W      = 12;
  localparam int ZP_W       = 12;
  localparam int LVL_W      = 24;
  localparam int HOLD_W     = 16;
  localparam int SQ_W       = 2 * SMP_W;
  localparam int SUM_W      = 37;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int MAX_WINDOW_SAMPLES = 4096;
  localparam int CNT_W  = $clog2(MAX_WINDOW_SAMPLES + 1);
  localparam int PROD_W = CNT_W + LVL_W;
  localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
  localparam logic [HOLD_W-1:0] TIMER_MAX = '1;

  localparam logic [ZP_W-1:0]   ZERO_POINT_RST = ZP_W'(1950);
  localparam logic [LVL_W-1:0]  ON_LEVEL_RST   = LVL_W'(1024);
  localparam logic [LVL_W-1:0]  OFF_LEVEL_RST  = LVL_W'(900);
  localparam logic [HOLD_W-1:0] ON_HOLD_RST    = HOLD_W'(250);
  localparam logic [HOLD_W-1:0] OFF_HOLD_RST   = HOLD_W'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_POINT = CFG_IDX_W'(0),
    REG_ON_LEVEL   = CFG_IDX_W'(1),
    REG_OFF_LEVEL  = CFG_IDX_W'(2),
    REG_ON_HOLD    = CFG_IDX_W'(3),
    REG_OFF_HOLD   = CFG_IDX_W'(4)
  } cfg_reg_e;

  typedef struct packed {
    logic [ZP_W-1:0]   zero_point;
    logic [LVL_W-1:0]  on_level_sq;
    logic [LVL_W-1:0]  off_level_sq;
    logic [HOLD_W-1:0] on_hold_ticks;
    logic [HOLD_W-1:0] off_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic              is_tick;
    logic              last;
    logic              add;
    logic [SQ_W-1:0]   sq;
    logic [PROD_W-1:0] prod_on;
    logic [PROD_W-1:0] prod_off;
  } sq_item_t;

endpackage

>>> sv/rmsd_item_if.sv
// ----------------------------------------------------------------------------
// rmsd_item_if
// Input item channel: ADC sample or millisecond tick.
// ----------------------------------------------------------------------------
interface rmsd_item_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [rmsd_pkg::SMP_W-1:0] sample;
  logic                       window_last;

  modport source (output valid, mode, sample, window_last, input ready);
  modport sink   (input valid, mode, sample, window_last, output ready);
endinterface

>>> sv/rmsd_result_if.sv
// ----------------------------------------------------------------------------
// rmsd_result_if
// Result channel: running flag, raw state and window close marker.
// ----------------------------------------------------------------------------
interface rmsd_result_if;
  logic valid;
  logic ready;
  logic pump_running;
  logic raw_on;
  logic window_done;

  modport source (output valid, pump_running, raw_on, window_done, input ready);
  modport sink   (input valid, pump_running, raw_on, window_done, output ready);
endinterface

>>> sv/rmsd_cfg_if.sv
// ----------------------------------------------------------------------------
// rmsd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rmsd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rmsd_pkg::CFG_IDX_W-1:0]  index;
  logic [rmsd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/rms_current_on_off_detector.sv
// ----------------------------------------------------------------------------
// rms_current_on_off_detector
// RMS level detector with hysteresis and tick-based debounce of the
// running flag.
//
//   channel   dir  fields                                   transfer
//   item_i    in   mode, sample, window_last                valid && ready
//   result_o  out  pump_running, raw_on, window_done        valid && ready
//   cfg_i     in   index, data                              valid && ready
//
// One item per cycle sustained while result_o.ready stays high. An input
// item passes in order through the input register, the square/product
// register and the result register.
// Reset clears the window, the raw state, the running flag and both timers.
// Each stage advances when the stage after it is empty or moving; a stalled
// result holds while earlier stages keep filling.
// ----------------------------------------------------------------------------
module rms_current_on_off_detector (
  input  logic          clk_i,
  input  logic          rst_ni,
  rmsd_item_if.sink     item_i,
  rmsd_result_if.source result_o,
  rmsd_cfg_if.sink      cfg_i
);

  rmsd_pkg::cfg_t     cfg;
  rmsd_pkg::sq_item_t sq_item;
  logic               sq_valid;
  logic               sq_ready;

  rmsd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rmsd_square_stage u_square_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_i      (cfg),
    .sq_valid_o (sq_valid),
    .sq_item_o  (sq_item),
    .sq_ready_i (sq_ready)
  );

  rmsd_decide_stage u_decide_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sq_valid_i (sq_valid),
    .sq_item_i  (sq_item),
    .sq_ready_o (sq_ready),
    .cfg_i      (cfg),
    .result_o   (result_o)
  );

  // running only sets while raw is on, and only clears while raw is off
  a_run_set_needs_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.pump_running) |-> result_o.raw_on)
    else $error("running flag set while raw state is off");

  a_run_clr_needs_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(result_o.pump_running) |-> !result_o.raw_on)
    else $error("running flag cleared while raw state is on");

  // raw state moves only on a window close
  a_raw_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(result_o.raw_on) |-> result_o.window_done)
    else $error("raw state changed without a window close");

endmodule

>>> sv/rmsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rmsd_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module rmsd_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  rmsd_cfg_if.sink       cfg_i,
  output rmsd_pkg::cfg_t cfg_o
);

  rmsd_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_point     <= rmsd_pkg::ZERO_POINT_RST;
      cfg_q.on_level_sq    <= rmsd_pkg::ON_LEVEL_RST;
      cfg_q.off_level_sq   <= rmsd_pkg::OFF_LEVEL_RST;
      cfg_q.on_hold_ticks  <= rmsd_pkg::ON_HOLD_RST;
      cfg_q.off_hold_ticks <= rmsd_pkg::OFF_HOLD_RST;
    end else if (cfg_i.valid) begin
      unique case (rmsd_pkg::cfg_reg_e'(cfg_i.index))
        rmsd_pkg::REG_ZERO_POINT: cfg_q.zero_point   <= cfg_i.data[rmsd_pkg::ZP_W-1:0];
        rmsd_pkg::REG_ON_LEVEL:   cfg_q.on_level_sq  <= cfg_i.data[rmsd_pkg::LVL_W-1:0];
        rmsd_pkg::REG_OFF_LEVEL:  cfg_q.off_level_sq <= cfg_i.data[rmsd_pkg::LVL_W-1:0];
        rmsd_pkg::REG_ON_HOLD: begin
          cfg_q.on_hold_ticks <= cfg_i.data[rmsd_pkg::HOLD_W-1:0];
        end
        rmsd_pkg::REG_OFF_HOLD: begin
          cfg_q.off_hold_ticks <= cfg_i.data[rmsd_pkg::HOLD_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/rmsd_square_stage.sv
// ----------------------------------------------------------------------------
// rmsd_square_stage
// Input register, window sample counter, squaring of the offset sample and
// count times level products for the window decision.
// ----------------------------------------------------------------------------
module rmsd_square_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  rmsd_item_if.sink          item_i,
  input  rmsd_pkg::cfg_t     cfg_i,
  output logic               sq_valid_o,
  output rmsd_pkg::sq_item_t sq_item_o,
  input  logic               sq_ready_i
);

  logic                          s1_valid_q;
  logic                          s1_mode_q;
  logic [rmsd_pkg::SMP_W-1:0]    s1_sample_q;
  logic                          s1_last_q;
  logic [rmsd_pkg::CNT_W-1:0]    count_q;
  logic [rmsd_pkg::CNT_W-1:0]    count_d;
  logic                          s2_valid_q;
  rmsd_pkg::sq_item_t            s2_q;
  rmsd_pkg::sq_item_t            s2_d;
  logic                          s2_load;
  logic                          s1_load;
  logic [rmsd_pkg::SMP_W-1:0]    mag;
  logic [rmsd_pkg::CNT_W-1:0]    cnt_new;
  logic                          add;

  assign s2_load      = s1_valid_q && (!s2_valid_q || sq_ready_i);
  assign item_i.ready = !s1_valid_q || s2_load;
  assign s1_load      = item_i.valid && item_i.ready;

  assign sq_valid_o = s2_valid_q;
  assign sq_item_o  = s2_q;

  always_comb begin
    mag = (s1_sample_q >= cfg_i.zero_point) ? (s1_sample_q - cfg_i.zero_point)
                                             : (cfg_i.zero_point - s1_sample_q);
    // drop samples once the window is full
    add     = !s1_mode_q &&
              (count_q < rmsd_pkg::CNT_W'(rmsd_pkg::MAX_WINDOW_SAMPLES));
    cnt_new = add ? count_q + rmsd_pkg::CNT_W'(1) : count_q;

    s2_d.is_tick  = s1_mode_q;
    s2_d.last     = s1_last_q;
    s2_d.add      = add;
    s2_d.sq       = rmsd_pkg::SQ_W'(mag) * rmsd_pkg::SQ_W'(mag);
    s2_d.prod_on  = rmsd_pkg::PROD_W'(cnt_new) * rmsd_pkg::PROD_W'(cfg_i.on_level_sq);
    s2_d.prod_off = rmsd_pkg::PROD_W'(cnt_new) * rmsd_pkg::PROD_W'(cfg_i.off_level_sq);

    count_d = count_q;
    if (!s1_mode_q) begin
      count_d = s1_last_q ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      count_q    <= '0;
    end else begin
      if (item_i.ready) begin
        s1_valid_q <= item_i.valid;
      end
      if (!s2_valid_q || sq_ready_i) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s2_load) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mode_q   <= item_i.mode;
      s1_sample_q <= item_i.sample;
      s1_last_q   <= item_i.window_last;
    end
    if (s2_load) begin
      s2_q <= s2_d;
    end
  end

endmodule

>>> sv/rmsd_decide_stage.sv
// ----------------------------------------------------------------------------
// rmsd_decide_stage
// Square sum accumulator, hysteresis decision at window close, debounce
// timers on ticks, and the result register.
// ----------------------------------------------------------------------------
module rmsd_decide_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sq_valid_i,
  input  rmsd_pkg::sq_item_t sq_item_i,
  output logic               sq_ready_o,
  input  rmsd_pkg::cfg_t     cfg_i,
  rmsd_result_if.source      result_o
);

  logic                        res_valid_q;
  logic                        done_q;
  logic                        done_d;
  logic [rmsd_pkg::SUM_W-1:0]  sum_q;
  logic [rmsd_pkg::SUM_W-1:0]  sum_d;
  logic                        raw_q;
  logic                        raw_d;
  logic                        run_q;
  logic                        run_d;
  logic [rmsd_pkg::HOLD_W-1:0] on_t_q;
  logic [rmsd_pkg::HOLD_W-1:0] on_t_d;
  logic [rmsd_pkg::HOLD_W-1:0] off_t_q;
  logic [rmsd_pkg::HOLD_W-1:0] off_t_d;
  logic                        load;
  logic [rmsd_pkg::SUM_W:0]    sum_ext;
  logic [rmsd_pkg::SUM_W-1:0]  sum_new;
  logic [rmsd_pkg::HOLD_W:0]   on_inc;
  logic [rmsd_pkg::HOLD_W:0]   off_inc;
  logic                        on_pass;
  logic                        off_pass;

  assign sq_ready_o = !res_valid_q || result_o.ready;
  assign load       = sq_valid_i && sq_ready_o;

  assign result_o.valid        = res_valid_q;
  assign result_o.pump_running = run_q;
  assign result_o.raw_on       = raw_q;
  assign result_o.window_done  = done_q;

  always_comb begin
    sum_ext  = {1'b0, sum_q} + (rmsd_pkg::SUM_W + 1)'(sq_item_i.sq);
    sum_new  = sum_q;
    if (sq_item_i.add) begin
      sum_new = sum_ext[rmsd_pkg::SUM_W] ? rmsd_pkg::SUM_MAX
                                          : sum_ext[rmsd_pkg::SUM_W-1:0];
    end

    // pass test on the unsaturated increment
    on_inc   = {1'b0, on_t_q} + (rmsd_pkg::HOLD_W + 1)'(1);
    off_inc  = {1'b0, off_t_q} + (rmsd_pkg::HOLD_W + 1)'(1);
    on_pass  = on_inc > {1'b0, cfg_i.on_hold_ticks};
    off_pass = off_inc > {1'b0, cfg_i.off_hold_ticks};

    sum_d   = sum_q;
    raw_d   = raw_q;
    run_d   = run_q;
    on_t_d  = on_t_q;
    off_t_d = off_t_q;
    done_d  = 1'b0;

    if (sq_item_i.is_tick) begin
      priority if (raw_q && !run_q) begin
        on_t_d = on_inc[rmsd_pkg::HOLD_W] ? rmsd_pkg::TIMER_MAX
                                           : on_inc[rmsd_pkg::HOLD_W-1:0];
        if (on_pass) begin
          run_d   = 1'b1;
          off_t_d = '0;
        end
      end else if (!raw_q && run_q) begin
        off_t_d = off_inc[rmsd_pkg::HOLD_W] ? rmsd_pkg::TIMER_MAX
                                             : off_inc[rmsd_pkg::HOLD_W-1:0];
        if (off_pass) begin
          run_d  = 1'b0;
          on_t_d = '0;
        end
      end else if (!raw_q) begin
        on_t_d = '0;
      end else begin
        off_t_d = '0;
      end
    end else if (sq_item_i.last) begin
      // closing sample is always counted or the window is full: never empty
      done_d = 1'b1;
      sum_d  = '0;
      if (raw_q) begin
        if (rmsd_pkg::CMP_W'(sum_new) < rmsd_pkg::CMP_W'(sq_item_i.prod_off)) begin
          raw_d = 1'b0;
        end
      end else begin
        if (rmsd_pkg::CMP_W'(sum_new) > rmsd_pkg::CMP_W'(sq_item_i.prod_on)) begin
          raw_d = 1'b1;
        end
      end
    end else begin
      sum_d = sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      done_q      <= 1'b0;
      sum_q       <= '0;
      raw_q       <= 1'b0;
      run_q       <= 1'b0;
      on_t_q      <= '0;
      off_t_q     <= '0;
    end else begin
      if (sq_ready_o) begin
        res_valid_q <= sq_valid_i;
      end
      if (load) begin
        done_q  <= done_d;
        sum_q   <= sum_d;
        raw_q   <= raw_d;
        run_q   <= run_d;
        on_t_q  <= on_t_d;
        off_t_q <= off_t_d;
      end
    end
  end

endmodule
